// ===== rtl/dwarf_encoded_value_decoder_macros.svh =====
// Assertion macros shared by the encoded-value decoder modules
`ifndef DWARF_ENCODED_VALUE_DECODER_MACROS_SVH
`define DWARF_ENCODED_VALUE_DECODER_MACROS_SVH

// Check a property on every clock edge; held off while reset is asserted
`define DEVD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define DEVD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/devd_pkg.sv =====
// Types, constants and helper functions for the encoded-value decoder
`default_nettype none

package devd_pkg;

	// Address unit in bytes: size of absptr and the alignment of the rounded application
	localparam int ADDR_UNIT_BYTES = 8;
	localparam int REM_W = $clog2(ADDR_UNIT_BYTES);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] ENC_OMIT = 8'hFF;

	// Formats (low nibble of the encoding)
	localparam logic [3:0] FMT_ABSPTR  = 4'h0;
	localparam logic [3:0] FMT_ULEB128 = 4'h1;
	localparam logic [3:0] FMT_UDATA2  = 4'h2;
	localparam logic [3:0] FMT_UDATA4  = 4'h3;
	localparam logic [3:0] FMT_UDATA8  = 4'h4;
	localparam logic [3:0] FMT_SLEB128 = 4'h9;
	localparam logic [3:0] FMT_SDATA2  = 4'hA;
	localparam logic [3:0] FMT_SDATA4  = 4'hB;
	localparam logic [3:0] FMT_SDATA8  = 4'hC;

	// Applications (high nibble of the encoding)
	localparam logic [3:0] APP_ABS     = 4'h0;
	localparam logic [3:0] APP_PCREL   = 4'h1;
	localparam logic [3:0] APP_TEXTREL = 4'h2;
	localparam logic [3:0] APP_DATAREL = 4'h3;
	localparam logic [3:0] APP_FUNCREL = 4'h4;
	localparam logic [3:0] APP_ALIGNED = 4'h5;

	localparam logic [3:0] LEB_MAX_BYTES = 4'd9;
	localparam logic [3:0] LEB_LONG_USED = 4'd10;

	// Configuration register indexes
	localparam logic [1:0] CFG_PC_BASE   = 2'd0;
	localparam logic [1:0] CFG_TEXT_BASE = 2'd1;
	localparam logic [1:0] CFG_DATA_BASE = 2'd2;
	localparam logic [1:0] CFG_FUNC_BASE = 2'd3;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OMITTED  = 3'd1,
		ST_BAD_FMT  = 3'd2,
		ST_BAD_APP  = 3'd3,
		ST_LEB_LONG = 3'd4
	} status_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic [7:0] encoding;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [3:0]         bytes_used;
		logic [2:0]         status;
	} out_word_t;

	// Queue entry: raw value from the front, applied by the back
	typedef struct packed {
		logic [63:0] acc;
		logic [3:0]  used;
		status_t     status;
		logic [3:0]  app;
	} qent_t;

	typedef struct packed {
		logic [63:0] pc_base;
		logic [63:0] text_base;
		logic [63:0] data_base;
		logic [63:0] func_base;
	} bases_t;

	typedef logic [REM_W-1:0] rem_t;
	typedef rem_t rem_tab_t [256];
	typedef rem_t nib_wt_t [16];

	function automatic logic fmt_known(logic [3:0] fmt);
		logic ok;
		case (fmt)
			FMT_ABSPTR, FMT_ULEB128, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
			FMT_SLEB128, FMT_SDATA2, FMT_SDATA4, FMT_SDATA8: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Byte count of a fixed format; zero for LEB128 and unknown formats
	function automatic logic [3:0] fmt_size(logic [3:0] fmt);
		logic [3:0] sz;
		case (fmt)
			FMT_ABSPTR: sz = 4'(ADDR_UNIT_BYTES);
			FMT_UDATA2, FMT_SDATA2: sz = 4'd2;
			FMT_UDATA4, FMT_SDATA4: sz = 4'd4;
			FMT_UDATA8, FMT_SDATA8: sz = 4'd8;
			default: sz = 4'd0;
		endcase
		return sz;
	endfunction

	// x mod the address unit for every 8-bit x, built by counting
	function automatic rem_tab_t build_rem_tab();
		rem_tab_t tab;
		int r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			tab[i] = rem_t'(r);
			if (r == ADDR_UNIT_BYTES - 1) begin
				r = 0;
			end else begin
				r = r + 1;
			end
		end
		return tab;
	endfunction

	// 16^k mod the address unit, one weight per nibble of a 64-bit word
	function automatic nib_wt_t build_nib_wt();
		nib_wt_t wt;
		rem_tab_t tab;
		tab = build_rem_tab();
		wt[0] = tab[1];
		for (int k = 1; k < 16; k++) begin
			wt[k] = tab[8'({wt[k-1], 4'b0000})];
		end
		return wt;
	endfunction

	localparam rem_tab_t REM_TAB = build_rem_tab();
	localparam nib_wt_t NIB_WT = build_nib_wt();

endpackage

`default_nettype wire

// ===== rtl/devd_front.sv =====
// Front end: accepts words, tracks the encoding and gathers value bytes
`default_nettype none
`include "dwarf_encoded_value_decoder_macros.svh"

module devd_front import devd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	output logic     push,
	output qent_t    push_ent,
	input  logic     q_full
);

	logic        busy_q;
	logic [63:0] acc_q;
	logic [3:0]  idx_q;
	logic [7:0]  enc_q;

	logic        busy_d;
	logic [63:0] acc_d;
	logic [3:0]  idx_d;
	logic [7:0]  enc_d;

	logic        accept;
	logic [3:0]  fmt;
	logic [3:0]  app;
	logic        is_leb;
	logic        fmt_signed;
	logic [3:0]  size;
	logic [3:0]  idx_nx;
	logic [6:0]  leb_sh7;
	logic [6:0]  fill_sh7;
	logic [63:0] leb_acc;
	logic [63:0] leb_fin;
	logic [63:0] fix_acc;
	logic [63:0] fix_fin;
	status_t     fin_status;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign fmt        = enc_q[3:0];
	assign app        = enc_q[7:4];
	assign is_leb     = (fmt == FMT_ULEB128) || (fmt == FMT_SLEB128);
	assign fmt_signed = fmt[3];
	assign size       = fmt_size(fmt);
	assign idx_nx     = idx_q + 4'd1;
	assign fin_status = (app > APP_ALIGNED) ? ST_BAD_APP : ST_OK;

	// 7 * index for the LEB128 group position and the sign fill point
	assign leb_sh7  = {idx_q, 3'b000} - 7'(idx_q);
	assign fill_sh7 = {idx_nx, 3'b000} - 7'(idx_nx);

	always_comb begin
		leb_acc = acc_q | (64'(in_data.data_byte[6:0]) << leb_sh7[5:0]);
		leb_fin = leb_acc;
		if (fmt_signed && in_data.data_byte[6]) begin
			leb_fin = leb_acc | (~64'd0 << fill_sh7[5:0]);
		end

		fix_acc = acc_q | (64'(in_data.data_byte) << {idx_q[2:0], 3'b000});
		fix_fin = fix_acc;
		if (fmt_signed && (size == 4'd2) && fix_acc[15]) begin
			fix_fin = fix_acc | (~64'd0 << 16);
		end else if (fmt_signed && (size == 4'd4) && fix_acc[31]) begin
			fix_fin = fix_acc | (~64'd0 << 32);
		end
	end

	always_comb begin
		busy_d          = busy_q;
		acc_d           = acc_q;
		idx_d           = idx_q;
		enc_d           = enc_q;
		push            = 1'b0;
		push_ent.acc    = '0;
		push_ent.used   = '0;
		push_ent.status = ST_OK;
		push_ent.app    = app;

		if (accept) begin
			if (in_data.req_type) begin
				// start word: drop any partial value and latch the new encoding
				busy_d = 1'b0;
				acc_d  = '0;
				idx_d  = '0;
				enc_d  = in_data.encoding;
				if (in_data.encoding == ENC_OMIT) begin
					push            = 1'b1;
					push_ent.status = ST_OMITTED;
				end else if (!fmt_known(in_data.encoding[3:0])) begin
					push            = 1'b1;
					push_ent.status = ST_BAD_FMT;
				end else begin
					busy_d = 1'b1;
				end
			end else if (busy_q) begin
				if (is_leb) begin
					if (idx_q >= LEB_MAX_BYTES) begin
						busy_d          = 1'b0;
						push            = 1'b1;
						push_ent.used   = LEB_LONG_USED;
						push_ent.status = ST_LEB_LONG;
					end else begin
						acc_d = leb_acc;
						idx_d = idx_nx;
						if (!in_data.data_byte[7]) begin
							busy_d          = 1'b0;
							push            = 1'b1;
							push_ent.acc    = leb_fin;
							push_ent.used   = idx_nx;
							push_ent.status = fin_status;
						end
					end
				end else begin
					acc_d = fix_acc;
					idx_d = idx_nx;
					if (idx_nx == size) begin
						busy_d          = 1'b0;
						push            = 1'b1;
						push_ent.acc    = fix_fin;
						push_ent.used   = idx_nx;
						push_ent.status = fin_status;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			acc_q  <= '0;
			idx_q  <= '0;
			enc_q  <= '0;
		end else begin
			busy_q <= busy_d;
			acc_q  <= acc_d;
			idx_q  <= idx_d;
			enc_q  <= enc_d;
		end
	end

	`DEVD_ASSERT_IMP(a_busy_fmt_known, busy_q, fmt_known(enc_q[3:0]), "busy on unknown format")
	`DEVD_ASSERT_IMP(a_leb_idx_range, busy_q && is_leb, idx_q <= LEB_MAX_BYTES, "LEB index overrun")

endmodule

`default_nettype wire

// ===== rtl/devd_queue.sv =====
// Short queue of raw values between the front and the back
`default_nettype none
`include "dwarf_encoded_value_decoder_macros.svh"

module devd_queue import devd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_ent,
	output logic  full,
	output logic  pop_valid,
	input  logic  pop_ready,
	output qent_t pop_ent
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qent_t             ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pop;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_ent   = ent_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	`DEVD_ASSERT_IMP(a_no_push_full, push, !full, "push into a full queue")
	`DEVD_ASSERT(a_cnt_range, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ===== rtl/devd_back.sv =====
// Back end: applies base or alignment and holds the output register
`default_nettype none
`include "dwarf_encoded_value_decoder_macros.svh"

module devd_back import devd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  qent_t     q_ent,
	input  bases_t    bases,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	// 16 nibbles times a weight below 8 stays under 2^11
	localparam int MSUM_W = 11;

	logic              valid_s1;
	logic [63:0]       val_s1;
	logic [MSUM_W-1:0] msum_s1;
	logic              round_s1;
	logic [3:0]        used_s1;
	status_t           status_s1;

	logic              valid_s2;
	out_word_t         out_s2;

	logic              s1_adv;
	logic              s2_load;
	logic [63:0]       val_d;
	logic [MSUM_W-1:0] msum_d;
	logic [7:0]        fold;
	rem_t              rem;
	logic [3:0]        pad;
	logic [63:0]       value_d;
	logic              out_err;

	assign s2_load = !valid_s2 || out_ready;
	assign s1_adv  = !valid_s1 || s2_load;
	assign q_ready = s1_adv;

	// stage 1: base add, and the nibble-weighted sum for the remainder
	always_comb begin
		case (q_ent.app)
			APP_PCREL:   val_d = q_ent.acc + bases.pc_base;
			APP_TEXTREL: val_d = q_ent.acc + bases.text_base;
			APP_DATAREL: val_d = q_ent.acc + bases.data_base;
			APP_FUNCREL: val_d = q_ent.acc + bases.func_base;
			default:     val_d = q_ent.acc;
		endcase

		msum_d = '0;
		for (int k = 0; k < 16; k++) begin
			msum_d = msum_d + MSUM_W'(q_ent.acc[4*k +: 4]) * MSUM_W'(NIB_WT[k]);
		end
	end

	// stage 2: fold the sum once more, look up the remainder, pad up to the unit, zero error values
	always_comb begin
		fold = 8'(msum_s1[3:0])
			+ 8'(msum_s1[7:4]) * 8'(NIB_WT[1])
			+ 8'(msum_s1[10:8]) * 8'(NIB_WT[2]);
		rem  = REM_TAB[fold];
		pad  = (rem == '0) ? 4'd0 : 4'(ADDR_UNIT_BYTES) - 4'(rem);
		value_d = round_s1 ? (val_s1 + 64'(pad)) : val_s1;
		if (status_s1 != ST_OK) begin
			value_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= q_valid;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && q_valid) begin
			val_s1    <= val_d;
			msum_s1   <= msum_d;
			round_s1  <= (q_ent.app == APP_ALIGNED);
			used_s1   <= q_ent.used;
			status_s1 <= q_ent.status;
		end
		if (s2_load && valid_s1) begin
			out_s2.value      <= value_d;
			out_s2.bytes_used <= used_s1;
			out_s2.status     <= status_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;
	assign out_err   = valid_s2 && (out_s2.status != ST_OK);

	`DEVD_ASSERT_IMP(a_err_value_zero, out_err, out_s2.value == '0, "error word not zero")

endmodule

`default_nettype wire

// ===== rtl/dwarf_encoded_value_decoder.sv =====
// Top level of the DWARF pointer-encoding value decoder
//
//  channel   dir  handshake              payload
//  in        in   in_valid / in_ready    in_data   (req_type, data_byte, encoding)
//  out       out  out_valid / out_ready  out_data  (value, bytes_used, status)
//  cfg       in   cfg_wr_en              cfg_index, cfg_wdata (four 64-bit bases)
//
// Rate: one input word per cycle while the queue has room, set by the front's single
//   byte-merge step and one 64-bit add per back-end stage.
// Path: the word completing a result is registered in the queue, then in stage 1,
//   then in the output register, which drives out_data.
// Stalls: in_ready drops only while the two-entry queue is full, which happens
//   when out_ready is held low; the back drains the queue on its own.
// Reset: arst_n clears the front state, queue pointers, pipeline valids and the
//   base registers at once; there is no clearing pass.
`default_nettype none

module dwarf_encoded_value_decoder import devd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	bases_t bases_q;

	logic  push;
	qent_t push_ent;
	logic  q_full;
	logic  q_valid;
	logic  q_ready;
	qent_t q_ent;

	// Base registers: the user must write them only while the block is idle (not enforced here); read live by the back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bases_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PC_BASE:   bases_q.pc_base   <= cfg_wdata;
				CFG_TEXT_BASE: bases_q.text_base <= cfg_wdata;
				CFG_DATA_BASE: bases_q.data_base <= cfg_wdata;
				CFG_FUNC_BASE: bases_q.func_base <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Front: classify each word, gather bytes, push finished raw values
	devd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.push_ent (push_ent),
		.q_full   (q_full)
	);

	// Queue: lets the front keep taking words while the output is stalled, until the queue is full
	devd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_ent   (q_ent)
	);

	// Back: add the selected base or round up, zero error values, hold the word
	devd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_ent     (q_ent),
		.bases     (bases_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
